### rtl/mfps_pkg.sv
`timescale 1ns / 1ps

package mfps_pkg;

   localparam int ELEM_W       = 16;   // matrix element, two's complement
   localparam int SUM_W        = 24;   // path sum, wraps at this width
   localparam int OUT_W        = 23;   // reported minimum
   localparam int SIZE_W       = 8;    // matrix size register
   localparam int MAX_SIZE_DEF = 128;  // default depth of the row buffer

   localparam int REQ_TDATA_W  = ((ELEM_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((OUT_W + 7) / 8) * 8;

endpackage

### rtl/min_falling_path_sum.sv
`timescale 1ns / 1ps

// Minimum falling path sum over a square matrix streamed in row-major order,
// one word per cycle on req_. The size (rows = columns, 0 reads as 1, clamped
// to MAX_SIZE) is written on csr_, which also restarts the matrix. After the
// last element of each matrix one word carrying the smallest path sum is
// offered on rsp_; rsp_tvalid rises when that element leaves the compute stage.
// Throughput is one element
// per clock: the previous row of sums sits in a single-port-write,
// single-port-read memory, each element reads one entry ahead (its upper-right
// neighbor) while the sum of the element before is written back, and a
// two-entry window plus a write-to-read bypass supply the other neighbors.
// req_tready drops only while a result is waiting in the output register and
// the element that closes the next matrix is ready to complete. No clearing
// pass is needed after reset.
module min_falling_path_sum #(
   parameter int MAX_SIZE = mfps_pkg::MAX_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // csr: matrix_size[7:0]
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mfps_pkg::SIZE_W-1:0]      csr_data,
   // req_tdata: element_value[15:0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mfps_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: min_path_sum[22:0], zero [23]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mfps_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int NW = (mfps_pkg::SIZE_W > CW + 1) ? mfps_pkg::SIZE_W : CW + 1;
   localparam int SW = mfps_pkg::SUM_W;
   localparam int EW = mfps_pkg::ELEM_W;
   localparam int OW = mfps_pkg::OUT_W;

   // configuration and position counters
   logic [mfps_pkg::SIZE_W-1:0] size_ff;
   logic [CW-1:0]               row_ff, row_in;
   logic [CW-1:0]               col_ff, col_in;
   logic [NW-1:0]               size_ext, n_eff;
   logic                        col_last, row_last, accept, csr_wr;
   logic [CW-1:0]               rd_addr;

   // compute stage
   logic                        b_valid_ff;
   logic signed [EW-1:0]        b_elem_ff;
   logic [CW-1:0]               b_col_ff;
   logic                        b_first_row_ff, b_last_row_ff;
   logic                        b_first_col_ff, b_last_col_ff;
   logic                        b_emits, b_go;

   // row buffer and its neighbor window
   logic signed [SW-1:0]        mem [MAX_SIZE];
   logic signed [SW-1:0]        rd_ff, fwd_data_ff, rd_val;
   logic                        fwd_hit_ff;
   logic signed [SW-1:0]        up_ff, held_ff, runmin_ff, runmin_in;
   logic signed [SW-1:0]        mn_a, mn_b, elem_ext, sum;

   // output register
   logic                        rsp_valid_ff;
   logic [OW-1:0]               rsp_data_ff;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_comb begin
      size_ext = NW'(size_ff);
      if (size_ext == '0) begin
         n_eff = NW'(1);
      end else if (size_ext > NW'(MAX_SIZE)) begin
         n_eff = NW'(MAX_SIZE);
      end else begin
         n_eff = size_ext;
      end
   end

   assign col_last = (NW'(col_ff) + NW'(1)) == n_eff;
   assign row_last = (NW'(row_ff) + NW'(1)) == n_eff;
   // prefetch the upper-right neighbor; at a row end fetch column 0 for the next row
   assign rd_addr  = col_last ? '0 : CW'(col_ff + 1'b1);

   assign b_emits    = b_last_row_ff & b_last_col_ff;
   assign b_go       = b_valid_ff & (~b_emits | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~b_valid_ff | b_go;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : CW'(row_ff + 1'b1);
      end else begin
         col_in = CW'(col_ff + 1'b1);
         row_in = row_ff;
      end
   end

   // three-way minimum over the previous row, then add
   always_comb begin
      rd_val   = fwd_hit_ff ? fwd_data_ff : rd_ff;
      elem_ext = {{(SW - EW){b_elem_ff[EW-1]}}, b_elem_ff};
      mn_a     = (!b_first_col_ff && (held_ff < up_ff)) ? held_ff : up_ff;
      mn_b     = (!b_last_col_ff && (rd_val < mn_a)) ? rd_val : mn_a;
      sum      = b_first_row_ff ? elem_ext : SW'(mn_b + elem_ext);
      if (b_last_row_ff && (b_first_col_ff || (sum < runmin_ff))) begin
         runmin_in = sum;
      end else begin
         runmin_in = runmin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         mem[b_col_ff] <= sum;
      end
      if (accept) begin
         rd_ff       <= mem[rd_addr];
         // bypass the write-back landing in the same cycle
         fwd_hit_ff  <= b_go && (b_col_ff == rd_addr);
         fwd_data_ff <= sum;
         b_elem_ff      <= req_tdata[EW-1:0];
         b_col_ff       <= col_ff;
         b_first_row_ff <= (row_ff == '0);
         b_last_row_ff  <= row_last;
         b_first_col_ff <= (col_ff == '0);
         b_last_col_ff  <= col_last;
      end
      if (b_go && b_emits) begin
         rsp_data_ff <= runmin_in[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= mfps_pkg::SIZE_W'(1);
         row_ff       <= '0;
         col_ff       <= '0;
         b_valid_ff   <= 1'b0;
         up_ff        <= '0;
         held_ff      <= '0;
         runmin_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            size_ff   <= csr_data;
            row_ff    <= '0;
            col_ff    <= '0;
            up_ff     <= '0;
            held_ff   <= '0;
            runmin_ff <= '0;
         end else begin
            if (accept) begin
               row_ff <= row_in;
               col_ff <= col_in;
            end
            if (b_go) begin
               // slide the window one column to the right
               held_ff   <= up_ff;
               up_ff     <= rd_val;
               runmin_ff <= b_emits ? '0 : runmin_in;
            end
         end
         if (accept) begin
            b_valid_ff <= 1'b1;
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
         if (b_go && b_emits) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mfps_pkg::RSP_TDATA_W'(rsp_data_ff);

`ifndef NO_ASSERTIONS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (NW'(row_ff) < n_eff) && (NW'(col_ff) < n_eff))
      else $error("row or column counter beyond matrix size");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (b_valid_ff && b_emits && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked result");

   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (b_go && b_emits) |=> rsp_tvalid)
      else $error("finished matrix produced no result");
`endif

endmodule
